### hw/rtl/i2c_light_sensor_reader_defines.svh
// ----------------------------------------------------------------------------
// Light sensor reader assertion macros
// Shared concurrent assertion forms for the reader RTL.
// ----------------------------------------------------------------------------
`ifndef I2C_LIGHT_SENSOR_READER_DEFINES_SVH
`define I2C_LIGHT_SENSOR_READER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ILSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ILSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ilsr_pkg.sv
// ----------------------------------------------------------------------------
// Light sensor reader package
// Types and constants shared by the reader sequencer, scaler and top level.
// ----------------------------------------------------------------------------
package ilsr_pkg;

	localparam int unsigned ADDR_W   = 8;
	localparam int unsigned CMD_W    = 8;
	localparam int unsigned HALF_W   = 16;
	localparam int unsigned SETTLE_W = 24;
	localparam int unsigned DATA_W   = 16;
	localparam int unsigned SCALE_W  = 18;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CMD_W-1:0]    CMD_POWER_ON     = 8'h01;
	localparam logic [ADDR_W-1:0]   RST_WRITE_ADDR   = 8'd70;
	localparam logic [CMD_W-1:0]    RST_MODE_CMD     = 8'd16;
	localparam logic [HALF_W-1:0]   RST_HALF_TICKS   = 16'd1;
	localparam logic [SETTLE_W-1:0] RST_SETTLE_TICKS = 24'd10;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_ST_A   = 4'd1,
		PH_ST_B   = 4'd2,
		PH_ST_C   = 4'd3,
		PH_WB_LO  = 4'd4,
		PH_WB_HI  = 4'd5,
		PH_AK_LO  = 4'd6,
		PH_AK_HI  = 4'd7,
		PH_RB_LO  = 4'd8,
		PH_RB_HI  = 4'd9,
		PH_MA_LO  = 4'd10,
		PH_MA_HI  = 4'd11,
		PH_SP_A   = 4'd12,
		PH_SP_B   = 4'd13,
		PH_SP_C   = 4'd14,
		PH_SETTLE = 4'd15
	} phase_t;

	typedef enum logic [1:0] {
		TXN_POWER_A = 2'd0,
		TXN_POWER_B = 2'd1,
		TXN_MODE    = 2'd2,
		TXN_READ    = 2'd3
	} txn_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WRITE_ADDR = 2'd0,
		CFG_MODE_CMD   = 2'd1,
		CFG_HALF_TICKS = 2'd2,
		CFG_SETTLE     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   write_address_byte;
		logic [CMD_W-1:0]    mode_command;
		logic [HALF_W-1:0]   half_bit_ticks;
		logic [SETTLE_W-1:0] settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic              scl_level;
		logic              sda_level;
		logic              sda_drive;
		logic              busy_res;
		logic              done_res;
		logic [DATA_W-1:0] raw_count;
		logic [DATA_W-1:0] lux_value;
		logic              saturated;
		logic              ack_error;
	} res_t;

endpackage

### hw/rtl/ilsr_scale.sv
// ----------------------------------------------------------------------------
// Light sensor reader scaler
// Multiplies the raw count by an unsigned Q.16 factor, truncates, saturates.
// ----------------------------------------------------------------------------
module ilsr_scale #(
	parameter int unsigned SCALE_Q16 = 115967
) (
	input  logic [ilsr_pkg::DATA_W-1:0] raw,
	output logic [ilsr_pkg::DATA_W-1:0] lux,
	output logic                        sat
);

	localparam int unsigned PROD_W = ilsr_pkg::DATA_W + ilsr_pkg::SCALE_W;
	localparam int unsigned HI_W   = PROD_W - 16;

	logic [ilsr_pkg::SCALE_W-1:0] scale;
	logic [PROD_W-1:0]            prod;
	logic [HI_W-1:0]              prod_hi;

	assign scale   = ilsr_pkg::SCALE_W'(SCALE_Q16);
	assign prod    = PROD_W'(raw) * PROD_W'(scale);
	assign prod_hi = prod[PROD_W-1:16];
	assign sat     = |prod_hi[HI_W-1:ilsr_pkg::DATA_W];
	assign lux     = sat ? '1 : prod_hi[ilsr_pkg::DATA_W-1:0];

endmodule

### hw/rtl/ilsr_seq.sv
// ----------------------------------------------------------------------------
// Light sensor reader sequencer
// Tick-driven bus state machine: start, bytes, acks, stop, settle, read.
// ----------------------------------------------------------------------------
`include "i2c_light_sensor_reader_defines.svh"

module ilsr_seq #(
	parameter int unsigned SCALE_Q16 = 115967
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            start_request,
	input  logic            sda_in,
	input  ilsr_pkg::cfg_t  cfg,
	output ilsr_pkg::res_t  res
);

	ilsr_pkg::phase_t phase_q, n_phase, cur_phase, tgt;
	ilsr_pkg::txn_t   txn_q, n_txn, cur_txn;
	logic [3:0]                    bit_q, n_bit, bit_inc;
	logic [ilsr_pkg::SETTLE_W-1:0] dly_q, n_dly, cur_dly, half_m1;
	logic [7:0]                    shift_q, n_shift;
	logic [7:0]                    first_q, n_first;
	logic                          slot_q, n_slot;
	logic [ilsr_pkg::DATA_W-1:0]   raw_q, n_raw, lux_q, n_lux, sc_lux;
	logic                          sat_q, n_sat, sc_sat;
	logic                          nack_q, n_nack;
	logic                          go, done;
	logic                          scl, sdl, drv;

	ilsr_scale #(.SCALE_Q16(SCALE_Q16)) u_scale (
		.raw ({first_q, shift_q}),
		.lux (sc_lux),
		.sat (sc_sat)
	);

	assign half_m1 = (cfg.half_bit_ticks == '0) ? '0 :
		ilsr_pkg::SETTLE_W'(cfg.half_bit_ticks - 16'd1);
	assign bit_inc = bit_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ilsr_pkg::PH_IDLE;
			txn_q   <= ilsr_pkg::TXN_POWER_A;
			bit_q   <= '0;
			dly_q   <= '0;
			shift_q <= '0;
			first_q <= '0;
			slot_q  <= 1'b0;
			raw_q   <= '0;
			lux_q   <= '0;
			sat_q   <= 1'b0;
			nack_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= n_phase;
			txn_q   <= n_txn;
			bit_q   <= n_bit;
			dly_q   <= n_dly;
			shift_q <= n_shift;
			first_q <= n_first;
			slot_q  <= n_slot;
			raw_q   <= n_raw;
			lux_q   <= n_lux;
			sat_q   <= n_sat;
			nack_q  <= n_nack;
		end
	end

	always_comb begin
		cur_phase = phase_q;
		cur_dly   = dly_q;
		cur_txn   = txn_q;
		if (phase_q == ilsr_pkg::PH_IDLE && start_request) begin
			cur_phase = ilsr_pkg::PH_ST_A;
			cur_dly   = half_m1;
			cur_txn   = ilsr_pkg::TXN_POWER_A;
		end

		scl = 1'b1;
		sdl = 1'b1;
		drv = 1'b1;
		unique case (cur_phase)
			ilsr_pkg::PH_ST_B: sdl = 1'b0;
			ilsr_pkg::PH_ST_C: begin
				scl = 1'b0;
				sdl = 1'b0;
			end
			ilsr_pkg::PH_WB_LO: begin
				scl = 1'b0;
				sdl = shift_q[7];
			end
			ilsr_pkg::PH_WB_HI: sdl = shift_q[7];
			ilsr_pkg::PH_AK_LO, ilsr_pkg::PH_RB_LO: begin
				scl = 1'b0;
				drv = 1'b0;
			end
			ilsr_pkg::PH_AK_HI, ilsr_pkg::PH_RB_HI: drv = 1'b0;
			ilsr_pkg::PH_MA_LO: begin
				scl = 1'b0;
				sdl = slot_q;
			end
			ilsr_pkg::PH_MA_HI: sdl = slot_q;
			ilsr_pkg::PH_SP_A: begin
				scl = 1'b0;
				sdl = 1'b0;
			end
			ilsr_pkg::PH_SP_B: sdl = 1'b0;
			ilsr_pkg::PH_IDLE, ilsr_pkg::PH_SP_C, ilsr_pkg::PH_SETTLE,
			ilsr_pkg::PH_ST_A: ;
		endcase

		n_phase = cur_phase;
		n_dly   = cur_dly;
		n_txn   = cur_txn;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_first = first_q;
		n_slot  = slot_q;
		n_raw   = raw_q;
		n_lux   = lux_q;
		n_sat   = sat_q;
		n_nack  = nack_q;
		go      = 1'b0;
		done    = 1'b0;
		tgt     = ilsr_pkg::PH_IDLE;

		if (cur_phase != ilsr_pkg::PH_IDLE) begin
			if (cur_dly != '0) begin
				n_dly = cur_dly - 24'd1;
			end else begin
				go = 1'b1;
				unique case (cur_phase)
					ilsr_pkg::PH_ST_A: tgt = ilsr_pkg::PH_ST_B;
					ilsr_pkg::PH_ST_B: tgt = ilsr_pkg::PH_ST_C;
					ilsr_pkg::PH_ST_C: begin
						n_slot  = 1'b0;
						n_bit   = '0;
						n_shift = (cur_txn == ilsr_pkg::TXN_READ) ?
							8'(cfg.write_address_byte + 8'd1) : cfg.write_address_byte;
						tgt     = ilsr_pkg::PH_WB_LO;
					end
					ilsr_pkg::PH_WB_LO: tgt = ilsr_pkg::PH_WB_HI;
					ilsr_pkg::PH_WB_HI: begin
						n_shift = {shift_q[6:0], 1'b0};
						n_bit   = bit_inc;
						tgt     = (bit_inc >= 4'd8) ? ilsr_pkg::PH_AK_LO : ilsr_pkg::PH_WB_LO;
					end
					ilsr_pkg::PH_AK_LO: tgt = ilsr_pkg::PH_AK_HI;
					ilsr_pkg::PH_AK_HI: begin
						if (sda_in) begin
							n_nack = 1'b1;
						end
						priority if (cur_txn == ilsr_pkg::TXN_READ) begin
							n_slot  = 1'b0;
							n_shift = '0;
							n_bit   = '0;
							tgt     = ilsr_pkg::PH_RB_LO;
						end else if (!slot_q) begin
							n_slot  = 1'b1;
							n_shift = (cur_txn == ilsr_pkg::TXN_MODE) ?
								cfg.mode_command : ilsr_pkg::CMD_POWER_ON;
							n_bit   = '0;
							tgt     = ilsr_pkg::PH_WB_LO;
						end else begin
							tgt = ilsr_pkg::PH_SP_A;
						end
					end
					ilsr_pkg::PH_RB_LO: tgt = ilsr_pkg::PH_RB_HI;
					ilsr_pkg::PH_RB_HI: begin
						n_shift = {shift_q[6:0], sda_in};
						n_bit   = bit_inc;
						tgt     = (bit_inc >= 4'd8) ? ilsr_pkg::PH_MA_LO : ilsr_pkg::PH_RB_LO;
					end
					ilsr_pkg::PH_MA_LO: tgt = ilsr_pkg::PH_MA_HI;
					ilsr_pkg::PH_MA_HI: begin
						if (!slot_q) begin
							n_first = shift_q;
							n_slot  = 1'b1;
							n_shift = '0;
							n_bit   = '0;
							tgt     = ilsr_pkg::PH_RB_LO;
						end else begin
							n_raw = {first_q, shift_q};
							n_lux = sc_lux;
							n_sat = sc_sat;
							tgt   = ilsr_pkg::PH_SP_A;
						end
					end
					ilsr_pkg::PH_SP_A: tgt = ilsr_pkg::PH_SP_B;
					ilsr_pkg::PH_SP_B: tgt = ilsr_pkg::PH_SP_C;
					ilsr_pkg::PH_SP_C: begin
						priority if (cur_txn == ilsr_pkg::TXN_POWER_A) begin
							n_txn = ilsr_pkg::TXN_POWER_B;
							tgt   = ilsr_pkg::PH_ST_A;
						end else if (cur_txn == ilsr_pkg::TXN_POWER_B) begin
							n_txn = ilsr_pkg::TXN_MODE;
							tgt   = ilsr_pkg::PH_ST_A;
						end else if (cur_txn == ilsr_pkg::TXN_MODE) begin
							n_txn = ilsr_pkg::TXN_READ;
							tgt   = ilsr_pkg::PH_SETTLE;
						end else begin
							n_txn   = ilsr_pkg::TXN_POWER_A;
							n_phase = ilsr_pkg::PH_IDLE;
							n_dly   = '0;
							go      = 1'b0;
							done    = 1'b1;
						end
					end
					ilsr_pkg::PH_SETTLE: tgt = ilsr_pkg::PH_ST_A;
					ilsr_pkg::PH_IDLE: go = 1'b0;
				endcase
			end
		end

		if (go) begin
			priority if (tgt == ilsr_pkg::PH_SETTLE && cfg.settle_ticks == '0) begin
				n_phase = ilsr_pkg::PH_ST_A;
				n_dly   = half_m1;
			end else if (tgt == ilsr_pkg::PH_SETTLE) begin
				n_phase = tgt;
				n_dly   = cfg.settle_ticks - 24'd1;
			end else begin
				n_phase = tgt;
				n_dly   = half_m1;
			end
		end
	end

	always_comb begin
		res.scl_level = scl;
		res.sda_level = sdl;
		res.sda_drive = drv;
		res.busy_res  = (cur_phase != ilsr_pkg::PH_IDLE);
		res.done_res  = done;
		res.raw_count = n_raw;
		res.lux_value = n_lux;
		res.saturated = n_sat;
		res.ack_error = n_nack;
	end

	`ILSR_ASSERT_NOW(a_idle_no_delay, clk, arst_n, phase_q == ilsr_pkg::PH_IDLE, dly_q == '0, "idle with a pending delay")
	`ILSR_ASSERT_NOW(a_bit_range, clk, arst_n, 1'b1, bit_q <= 4'd8, "bit counter past one byte")
	`ILSR_ASSERT_NEXT(a_done_to_idle, clk, arst_n, adv && done, phase_q == ilsr_pkg::PH_IDLE, "sequence end did not return to idle")

endmodule

### hw/rtl/i2c_light_sensor_reader.sv
// The result for a tick is registered and presented in the cycle after the tick transfer.
// Throughput: one tick per cycle; tick_stall rises only while a result is held.
// The bus sequencer advances one step per accepted tick, never per raw clock.
// Reset: configuration returns to 70, 16, 1, 10; the sequencer goes idle with
// cleared readings and error flag; no result is pending.
// ----------------------------------------------------------------------------
// Light sensor reader top level
// Tick-driven bus master that powers up, configures and reads a light sensor.
// ----------------------------------------------------------------------------
`include "i2c_light_sensor_reader_defines.svh"

module i2c_light_sensor_reader #(
	parameter int unsigned SCALE_Q16 = 115967
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                tick_valid,
	output logic                                tick_stall,
	input  logic                                start_request,
	input  logic                                sda_in,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                scl_level,
	output logic                                sda_level,
	output logic                                sda_drive,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [ilsr_pkg::DATA_W-1:0]         raw_count,
	output logic [ilsr_pkg::DATA_W-1:0]         lux_value,
	output logic                                saturated,
	output logic                                ack_error,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ilsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ilsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	ilsr_pkg::cfg_t cfg_q;
	ilsr_pkg::res_t res_nxt, res_q;
	logic           res_valid_q;
	logic           adv;

	assign cfg_ready  = 1'b1;
	assign tick_stall = res_valid_q & res_stall;
	assign adv        = tick_valid & ~tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_address_byte <= ilsr_pkg::RST_WRITE_ADDR;
			cfg_q.mode_command       <= ilsr_pkg::RST_MODE_CMD;
			cfg_q.half_bit_ticks     <= ilsr_pkg::RST_HALF_TICKS;
			cfg_q.settle_ticks       <= ilsr_pkg::RST_SETTLE_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ilsr_pkg::cfg_idx_t'(cfg_index))
				ilsr_pkg::CFG_WRITE_ADDR: cfg_q.write_address_byte <= cfg_data[7:0];
				ilsr_pkg::CFG_MODE_CMD:   cfg_q.mode_command       <= cfg_data[7:0];
				ilsr_pkg::CFG_HALF_TICKS: cfg_q.half_bit_ticks     <= cfg_data[15:0];
				ilsr_pkg::CFG_SETTLE:     cfg_q.settle_ticks       <= cfg_data[23:0];
			endcase
		end
	end

	ilsr_seq #(.SCALE_Q16(SCALE_Q16)) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.start_request (start_request),
		.sda_in        (sda_in),
		.cfg           (cfg_q),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign scl_level = res_q.scl_level;
	assign sda_level = res_q.sda_level;
	assign sda_drive = res_q.sda_drive;
	assign busy_res  = res_q.busy_res;
	assign done_res  = res_q.done_res;
	assign raw_count = res_q.raw_count;
	assign lux_value = res_q.lux_value;
	assign saturated = res_q.saturated;
	assign ack_error = res_q.ack_error;

	`ILSR_ASSERT_NEXT(a_tick_gives_result, clk, arst_n, adv, res_valid_q, "tick transfer produced no result")
	`ILSR_ASSERT_NOW(a_done_is_busy, clk, arst_n, res_valid_q && res_q.done_res, res_q.busy_res, "done outside a busy sequence")
	`ILSR_ASSERT_NOW(a_release_high, clk, arst_n, res_valid_q && !res_q.sda_drive, res_q.sda_level, "released data line not reported high")

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light sensor reader testbench
// Drives bus ticks into the reader with a simple sensor model on the data
// line, predicts every per-tick result and checks it against the block.
// Covers the default and extreme register settings, bus NACKs, saturation,
// and receiver back-pressure.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned LUX_SCALE          = 115967;
	localparam logic [15:0] SAT_EDGE           = 16'd37036;
	localparam int unsigned RANDOM_TICKS       = 100;
	localparam int unsigned BACKPRESSURE_TICKS = 100;
	localparam int unsigned LONG_HOLD          = 80;
	localparam int unsigned SLOW_BUS_TICKS     = 40;
	localparam int unsigned WATCHDOG_LIMIT     = 4000;
	localparam int unsigned MAX_REPORTS        = 10;

	logic                            clk;
	logic                            arst_n;
	logic                            tick_valid;
	logic                            tick_stall;
	logic                            start_request;
	logic                            sda_in;
	logic                            res_valid;
	logic                            res_stall;
	logic                            scl_level;
	logic                            sda_level;
	logic                            sda_drive;
	logic                            busy_res;
	logic                            done_res;
	logic [ilsr_pkg::DATA_W-1:0]     raw_count;
	logic [ilsr_pkg::DATA_W-1:0]     lux_value;
	logic                            saturated;
	logic                            ack_error;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [ilsr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ilsr_pkg::CFG_DATA_W-1:0] cfg_data;

	i2c_light_sensor_reader u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.start_request(start_request),
		.sda_in       (sda_in),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.scl_level    (scl_level),
		.sda_level    (sda_level),
		.sda_drive    (sda_drive),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.raw_count    (raw_count),
		.lux_value    (lux_value),
		.saturated    (saturated),
		.ack_error    (ack_error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	ilsr_pkg::cfg_t   bus_cfg;
	ilsr_pkg::phase_t seq_phase;
	ilsr_pkg::txn_t   seq_txn;
	logic [3:0]       seq_bits;
	logic [23:0]      seq_delay;
	logic [7:0]       seq_shift;
	logic [7:0]       seq_first;
	logic             seq_slot;
	logic [15:0]      seq_raw;
	logic [15:0]      seq_lux;
	logic             seq_over;
	logic             seq_nack;

	ilsr_pkg::res_t bus_result_q[$];
	int unsigned    ticks_sent;
	int unsigned    results_seen;
	int unsigned    fail_count;
	bit             idling_on;
	bit             hold_off_req;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void enter_phase(ilsr_pkg::phase_t p);
		logic [23:0] len;
		len = (p == ilsr_pkg::PH_SETTLE) ? bus_cfg.settle_ticks :
			{8'd0, bus_cfg.half_bit_ticks};
		if (p == ilsr_pkg::PH_SETTLE && len == 24'd0) begin
			p = ilsr_pkg::PH_ST_A;
			len = {8'd0, bus_cfg.half_bit_ticks};
		end
		if (len == 24'd0)
			len = 24'd1;
		seq_phase = p;
		seq_delay = len - 24'd1;
	endfunction

	function automatic logic finish_step(logic line);
		logic        done;
		logic [63:0] prod;
		done = 1'b0;
		case (seq_phase)
			ilsr_pkg::PH_ST_A: enter_phase(ilsr_pkg::PH_ST_B);
			ilsr_pkg::PH_ST_B: enter_phase(ilsr_pkg::PH_ST_C);
			ilsr_pkg::PH_ST_C: begin
				seq_slot = 1'b0;
				seq_bits = 4'd0;
				seq_shift = (seq_txn == ilsr_pkg::TXN_READ) ?
					bus_cfg.write_address_byte + 8'd1 : bus_cfg.write_address_byte;
				enter_phase(ilsr_pkg::PH_WB_LO);
			end
			ilsr_pkg::PH_WB_LO: enter_phase(ilsr_pkg::PH_WB_HI);
			ilsr_pkg::PH_WB_HI: begin
				seq_shift = seq_shift << 1;
				seq_bits = seq_bits + 4'd1;
				enter_phase(seq_bits >= 4'd8 ? ilsr_pkg::PH_AK_LO : ilsr_pkg::PH_WB_LO);
			end
			ilsr_pkg::PH_AK_LO: enter_phase(ilsr_pkg::PH_AK_HI);
			ilsr_pkg::PH_AK_HI: begin
				if (line)
					seq_nack = 1'b1;
				if (seq_txn == ilsr_pkg::TXN_READ) begin
					seq_slot = 1'b0;
					seq_shift = 8'd0;
					seq_bits = 4'd0;
					enter_phase(ilsr_pkg::PH_RB_LO);
				end else if (!seq_slot) begin
					seq_slot = 1'b1;
					seq_shift = (seq_txn == ilsr_pkg::TXN_MODE) ? bus_cfg.mode_command :
						ilsr_pkg::CMD_POWER_ON;
					seq_bits = 4'd0;
					enter_phase(ilsr_pkg::PH_WB_LO);
				end else begin
					enter_phase(ilsr_pkg::PH_SP_A);
				end
			end
			ilsr_pkg::PH_RB_LO: enter_phase(ilsr_pkg::PH_RB_HI);
			ilsr_pkg::PH_RB_HI: begin
				seq_shift = {seq_shift[6:0], line};
				seq_bits = seq_bits + 4'd1;
				enter_phase(seq_bits >= 4'd8 ? ilsr_pkg::PH_MA_LO : ilsr_pkg::PH_RB_LO);
			end
			ilsr_pkg::PH_MA_LO: enter_phase(ilsr_pkg::PH_MA_HI);
			ilsr_pkg::PH_MA_HI: begin
				if (!seq_slot) begin
					seq_first = seq_shift;
					seq_slot = 1'b1;
					seq_shift = 8'd0;
					seq_bits = 4'd0;
					enter_phase(ilsr_pkg::PH_RB_LO);
				end else begin
					seq_raw = {seq_first, seq_shift};
					prod = (64'(seq_raw) * 64'(LUX_SCALE)) >> 16;
					if (prod > 64'hFFFF) begin
						seq_lux = 16'hFFFF;
						seq_over = 1'b1;
					end else begin
						seq_lux = prod[15:0];
						seq_over = 1'b0;
					end
					enter_phase(ilsr_pkg::PH_SP_A);
				end
			end
			ilsr_pkg::PH_SP_A: enter_phase(ilsr_pkg::PH_SP_B);
			ilsr_pkg::PH_SP_B: enter_phase(ilsr_pkg::PH_SP_C);
			ilsr_pkg::PH_SP_C: begin
				case (seq_txn)
					ilsr_pkg::TXN_POWER_A: begin
						seq_txn = ilsr_pkg::TXN_POWER_B;
						enter_phase(ilsr_pkg::PH_ST_A);
					end
					ilsr_pkg::TXN_POWER_B: begin
						seq_txn = ilsr_pkg::TXN_MODE;
						enter_phase(ilsr_pkg::PH_ST_A);
					end
					ilsr_pkg::TXN_MODE: begin
						seq_txn = ilsr_pkg::TXN_READ;
						enter_phase(ilsr_pkg::PH_SETTLE);
					end
					default: begin
						seq_txn = ilsr_pkg::TXN_POWER_A;
						seq_phase = ilsr_pkg::PH_IDLE;
						seq_delay = 24'd0;
						done = 1'b1;
					end
				endcase
			end
			ilsr_pkg::PH_SETTLE: enter_phase(ilsr_pkg::PH_ST_A);
			default: begin
				seq_phase = ilsr_pkg::PH_IDLE;
				seq_delay = 24'd0;
			end
		endcase
		return done;
	endfunction

	function automatic ilsr_pkg::res_t step_sequencer(logic req, logic line);
		ilsr_pkg::res_t r;
		r = '0;
		if (seq_phase == ilsr_pkg::PH_IDLE && req) begin
			seq_txn = ilsr_pkg::TXN_POWER_A;
			enter_phase(ilsr_pkg::PH_ST_A);
		end
		r.busy_res = (seq_phase != ilsr_pkg::PH_IDLE);
		r.scl_level = 1'b1;
		r.sda_level = 1'b1;
		r.sda_drive = 1'b1;
		case (seq_phase)
			ilsr_pkg::PH_ST_B, ilsr_pkg::PH_SP_B: r.sda_level = 1'b0;
			ilsr_pkg::PH_ST_C, ilsr_pkg::PH_SP_A: begin
				r.scl_level = 1'b0;
				r.sda_level = 1'b0;
			end
			ilsr_pkg::PH_WB_LO: begin
				r.scl_level = 1'b0;
				r.sda_level = seq_shift[7];
			end
			ilsr_pkg::PH_WB_HI: r.sda_level = seq_shift[7];
			ilsr_pkg::PH_AK_LO, ilsr_pkg::PH_RB_LO: begin
				r.scl_level = 1'b0;
				r.sda_drive = 1'b0;
			end
			ilsr_pkg::PH_AK_HI, ilsr_pkg::PH_RB_HI: r.sda_drive = 1'b0;
			ilsr_pkg::PH_MA_LO: begin
				r.scl_level = 1'b0;
				r.sda_level = seq_slot;
			end
			ilsr_pkg::PH_MA_HI: r.sda_level = seq_slot;
			default: ;
		endcase
		if (seq_phase != ilsr_pkg::PH_IDLE) begin
			if (seq_delay == 24'd0)
				r.done_res = finish_step(line);
			else
				seq_delay = seq_delay - 24'd1;
		end
		r.raw_count = seq_raw;
		r.lux_value = seq_lux;
		r.saturated = seq_over;
		r.ack_error = seq_nack;
		return r;
	endfunction

	// sensor side of the bus: ack or nack, then the reading MSB first
	function automatic logic sensor_line(logic [15:0] reading, int nack_pct);
		case (seq_phase)
			ilsr_pkg::PH_AK_LO, ilsr_pkg::PH_AK_HI:
				return ($urandom_range(0, 99) < nack_pct);
			ilsr_pkg::PH_RB_LO, ilsr_pkg::PH_RB_HI:
				return reading[{~seq_slot, ~seq_bits[2:0]}];
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic string fmt_result(ilsr_pkg::res_t r);
		return $sformatf("scl=%b sda=%b drv=%b busy=%b done=%b raw=%h lux=%h sat=%b err=%b",
			r.scl_level, r.sda_level, r.sda_drive, r.busy_res, r.done_res,
			r.raw_count, r.lux_value, r.saturated, r.ack_error);
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	task automatic send_tick(logic req, logic line);
		if (idling_on && $urandom_range(0, 9) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		tick_valid    <= 1'b1;
		start_request <= req;
		sda_in        <= line;
		do @(posedge clk); while (tick_stall);
		bus_result_q.push_back(step_sequencer(req, line));
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic quiesce();
		tick_valid <= 1'b0;
		while (bus_result_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(ilsr_pkg::cfg_idx_t idx, logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ilsr_pkg::CFG_WRITE_ADDR: bus_cfg.write_address_byte = value[7:0];
			ilsr_pkg::CFG_MODE_CMD:   bus_cfg.mode_command = value[7:0];
			ilsr_pkg::CFG_HALF_TICKS: bus_cfg.half_bit_ticks = value[15:0];
			default:                  bus_cfg.settle_ticks = value;
		endcase
		@(negedge clk);
	endtask

	task automatic write_config(logic [7:0] addr, logic [7:0] mode, logic [15:0] half,
		logic [23:0] settle);
		quiesce();
		write_reg(ilsr_pkg::CFG_WRITE_ADDR, {16'd0, addr});
		write_reg(ilsr_pkg::CFG_MODE_CMD, {16'd0, mode});
		write_reg(ilsr_pkg::CFG_HALF_TICKS, {8'd0, half});
		write_reg(ilsr_pkg::CFG_SETTLE, settle);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_measurement(logic [15:0] reading, int nack_pct, int busy_req_pct);
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		while (seq_phase != ilsr_pkg::PH_IDLE)
			send_tick($urandom_range(0, 99) < busy_req_pct, sensor_line(reading, nack_pct));
	endtask

	task automatic test_idle_lines();
		for (int i = 0; i < 12; i++)
			send_tick(1'b0, 1'(i));
	endtask

	task automatic test_busy_request();
		run_measurement(SAT_EDGE, 0, 100);
	endtask

	task automatic test_saturation_edge();
		write_config(8'd0, 8'd0, 16'd1, 24'd0);
		run_measurement(SAT_EDGE + 16'd1, 0, 0);
	endtask

	task automatic test_nack();
		write_config(8'd254, 8'd255, 16'd1, 24'd0);
		run_measurement(16'hFFFF, 100, 0);
	endtask

	task automatic test_random_traffic();
		int unsigned first_tick;
		logic [7:0]  addr;
		logic [7:0]  mode;
		logic [15:0] half;
		logic [23:0] settle;
		logic [15:0] reading;
		first_tick = ticks_sent;
		while (ticks_sent - first_tick < RANDOM_TICKS) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 2))
					0:       addr = 8'd0;
					1:       addr = 8'd254;
					default: addr = 8'($urandom_range(0, 254));
				endcase
				case ($urandom_range(0, 2))
					0:       mode = 8'd0;
					1:       mode = 8'd255;
					default: mode = 8'($urandom);
				endcase
				half = 16'($urandom_range(1, 2));
				case ($urandom_range(0, 3))
					0:       settle = 24'd0;
					1:       settle = 24'd1;
					default: settle = 24'($urandom_range(2, 40));
				endcase
				write_config(addr, mode, half, settle);
			end
			case ($urandom_range(0, 5))
				0:       reading = 16'h0000;
				1:       reading = 16'hFFFF;
				2:       reading = SAT_EDGE;
				3:       reading = SAT_EDGE + 16'd1;
				default: reading = 16'($urandom);
			endcase
			run_measurement(reading, ($urandom_range(0, 3) == 0) ? 40 : 0, $urandom_range(0, 20));
			repeat ($urandom_range(0, 4))
				send_tick(1'b0, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_backpressure();
		logic [15:0] reading;
		reading = 16'($urandom);
		write_config(8'h46, 8'h11, 16'd1, 24'd5);
		hold_off_req = 1'b1;
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		repeat (BACKPRESSURE_TICKS - 1)
			send_tick(1'($urandom_range(0, 1)), sensor_line(reading, 0));
	endtask

	task automatic test_slow_bus();
		write_config(8'd254, 8'd255, 16'hFFFF, 24'hFFFFFF);
		send_tick(1'b1, 1'b0);
		repeat (SLOW_BUS_TICKS)
			send_tick(1'($urandom_range(0, 1)), sensor_line(16'($urandom), 0));
	endtask

	initial begin : res_stall_driver
		res_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				res_stall <= 1'b0;
			end else if (idling_on && $urandom_range(0, 9) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin : result_checker
		ilsr_pkg::res_t seen;
		ilsr_pkg::res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				seen.scl_level = scl_level;
				seen.sda_level = sda_level;
				seen.sda_drive = sda_drive;
				seen.busy_res  = busy_res;
				seen.done_res  = done_res;
				seen.raw_count = raw_count;
				seen.lux_value = lux_value;
				seen.saturated = saturated;
				seen.ack_error = ack_error;
				if (bus_result_q.size() == 0) begin
					note_failure($sformatf("unexpected result: %s", fmt_result(seen)));
				end else begin
					want = bus_result_q.pop_front();
					if (seen !== want)
						note_failure($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
							results_seen, fmt_result(want), fmt_result(seen)));
				end
				results_seen++;
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((tick_valid && !tick_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		arst_n        <= 1'b0;
		tick_valid    <= 1'b0;
		start_request <= 1'b0;
		sda_in        <= 1'b1;
		cfg_valid     <= 1'b0;
		cfg_index     <= ilsr_pkg::CFG_WRITE_ADDR;
		cfg_data      <= '0;
		idling_on     = 1'b1;
		hold_off_req  = 1'b0;
		ticks_sent    = 0;
		results_seen  = 0;
		fail_count    = 0;
		bus_cfg.write_address_byte = ilsr_pkg::RST_WRITE_ADDR;
		bus_cfg.mode_command       = ilsr_pkg::RST_MODE_CMD;
		bus_cfg.half_bit_ticks     = ilsr_pkg::RST_HALF_TICKS;
		bus_cfg.settle_ticks       = ilsr_pkg::RST_SETTLE_TICKS;
		seq_phase = ilsr_pkg::PH_IDLE;
		seq_txn   = ilsr_pkg::TXN_POWER_A;
		seq_bits  = '0;
		seq_delay = '0;
		seq_shift = '0;
		seq_first = '0;
		seq_slot  = 1'b0;
		seq_raw   = '0;
		seq_lux   = '0;
		seq_over  = 1'b0;
		seq_nack  = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_lines();
		test_busy_request();
		test_saturation_edge();
		test_nack();
		test_random_traffic();
		test_backpressure();
		idling_on = 1'b0;
		test_slow_bus();

		quiesce();
		repeat (8) @(negedge clk);
		if (bus_result_q.size() != 0)
			note_failure($sformatf("%0d results never arrived", bus_result_q.size()));
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ilsr_pkg.sv
hw/rtl/ilsr_scale.sv
hw/rtl/ilsr_seq.sv
hw/rtl/i2c_light_sensor_reader.sv
verif/testbench.sv
